@@ hdl/lcrt_pkg.sv @@
// Shared widths, types and field helpers for the longest consecutive run tracker.
package lcrt_pkg;

   localparam int VALUE_BITS    = 10;
   localparam int DEPTH         = 1 << VALUE_BITS;
   localparam int LEN_BITS      = VALUE_BITS + 1;
   localparam int TAG_BITS      = 8;
   localparam int VALUE_FIELD_W = 10;
   localparam int LEN_FIELD_W   = 11;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 16;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [LEN_BITS-1:0]   len_type;
   typedef logic [TAG_BITS-1:0]   tag_type;

   localparam value_type VAL_MAX     = '1;
   localparam tag_type   EPOCH_MAX   = '1;
   localparam tag_type   EPOCH_FIRST = tag_type'(1);
   localparam tag_type   TAG_NONE    = '0;

   // Request value field to the internal value range (upper bits ignored).
   function automatic value_type value_of(input logic [VALUE_FIELD_W-1:0] field);
      logic [VALUE_BITS+VALUE_FIELD_W-1:0] wide;
      wide = {{VALUE_BITS{1'b0}}, field};
      return wide[VALUE_BITS-1:0];
   endfunction

   // Internal length to the response field width.
   function automatic logic [LEN_FIELD_W-1:0] len_field(input len_type len);
      logic [LEN_BITS+LEN_FIELD_W-1:0] wide;
      wide = {{LEN_FIELD_W{1'b0}}, len};
      return wide[LEN_FIELD_W-1:0];
   endfunction

endpackage

@@ hdl/longest_consecutive_run_tracker_unit.sv @@
// Longest consecutive run tracker: takes one value per request and answers each request with
// the longest run of consecutive values seen in the current set. A request passes in order
// through accept, neighbour capture, join with left-end write and right-end write; the
// single write port of the run-length memory and the three tag reads over two read ports
// call for these steps. Presence is an epoch tag per value, so a new set costs nothing,
// except that once the tag wraps (every 255th new-set request) and once after reset a
// clearing pass over all 1024 tags runs before the next request is taken. A response
// waits in its own register; the next request is taken while it waits.
module longest_consecutive_run_tracker_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lcrt_pkg::REQ_DATA_W-1:0] req_tdata,  // [9:0] value, rest zero
   input  logic                          req_tuser,  // [0] new_set
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lcrt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [10:0] best_length, rest zero
   output logic                          rsp_tlast
);

   import lcrt_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ISSUE,
      S_READ,
      S_JOIN,
      S_RIGHT
   } state_type;

   state_type state_ff, state_in;
   value_type sweep_ff, sweep_in;
   logic      pend_ff, pend_in;
   tag_type   epoch_ff, epoch_in;
   len_type   best_ff, best_in;
   value_type v_ff, v_in;
   logic      last_ff, last_in;
   len_type   lft_ff, lft_in;
   len_type   rgt_ff, rgt_in;
   len_type   sum_ff, sum_in;
   value_type right_ff, right_in;
   logic      wr_right_ff, wr_right_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   len_type   rsp_best_ff, rsp_best_in;
   logic      rsp_last_ff, rsp_last_in;

   logic      accept;
   logic      advance;
   logic      dup;
   len_type   sum;
   value_type req_val;
   value_type base;
   value_type addr_a;
   value_type addr_b;
   tag_type   tag_a;
   tag_type   tag_b;
   len_type   len_a;
   len_type   len_b;
   logic      tag_we;
   value_type tag_waddr;
   tag_type   tag_wdata;
   logic      len_we;
   value_type len_waddr;

   assign req_val = value_of(req_tdata[VALUE_FIELD_W-1:0]);
   assign accept  = req_tvalid && req_tready;
   assign advance = !rsp_tvalid_ff || rsp_tready;
   assign dup     = (tag_a == epoch_ff);
   assign sum     = lft_ff + rgt_ff + len_type'(1);

   // Neighbour reads go out with the request; the self tag read follows in the next cycle.
   assign base   = (state_ff == S_IDLE) ? req_val : v_ff;
   assign addr_a = (state_ff == S_READ) ? v_ff : base - value_type'(1);
   assign addr_b = base + value_type'(1);

   always_comb begin
      tag_we    = 1'b0;
      tag_waddr = v_ff;
      tag_wdata = epoch_ff;
      len_we    = 1'b0;
      len_waddr = v_ff - lft_ff[VALUE_BITS-1:0];
      case (state_ff)
         S_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = sweep_ff;
            tag_wdata = TAG_NONE;
         end
         S_JOIN: begin
            tag_we = !dup;
            len_we = !dup;
         end
         S_RIGHT: begin
            len_we    = advance && wr_right_ff;
            len_waddr = right_ff;
         end
         default: begin
         end
      endcase
   end

   lcrt_ram #(
      .WIDTH(TAG_BITS),
      .DEPTH(DEPTH)
   ) u_tag_ram (
      .clock    (clock),
      .wr_en    (tag_we),
      .wr_addr  (tag_waddr),
      .wr_data  (tag_wdata),
      .rd_addr_a(addr_a),
      .rd_data_a(tag_a),
      .rd_addr_b(addr_b),
      .rd_data_b(tag_b)
   );

   lcrt_ram #(
      .WIDTH(LEN_BITS),
      .DEPTH(DEPTH)
   ) u_len_ram (
      .clock    (clock),
      .wr_en    (len_we),
      .wr_addr  (len_waddr),
      .wr_data  (sum_in),
      .rd_addr_a(addr_a),
      .rd_data_a(len_a),
      .rd_addr_b(addr_b),
      .rd_data_b(len_b)
   );

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      pend_in       = pend_ff;
      epoch_in      = epoch_ff;
      best_in       = best_ff;
      v_in          = v_ff;
      last_in       = last_ff;
      lft_in        = lft_ff;
      rgt_in        = rgt_ff;
      sum_in        = sum_ff;
      right_in      = right_ff;
      wr_right_in   = wr_right_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_best_in   = rsp_best_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + value_type'(1);
            if (sweep_ff == VAL_MAX) begin
               epoch_in = EPOCH_FIRST;
               pend_in  = 1'b0;
               state_in = pend_ff ? S_ISSUE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               v_in     = req_val;
               last_in  = req_tlast;
               state_in = S_READ;
               if (req_tuser) begin
                  best_in = '0;
                  if (epoch_ff == EPOCH_MAX) begin
                     // tags about to repeat: wipe the tag memory first
                     pend_in  = 1'b1;
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + tag_type'(1);
                  end
               end
            end
         end
         S_ISSUE: begin
            state_in = S_READ;
         end
         S_READ: begin
            lft_in   = (v_ff != '0 && tag_a == epoch_ff) ? len_a : '0;
            rgt_in   = (v_ff != VAL_MAX && tag_b == epoch_ff) ? len_b : '0;
            state_in = S_JOIN;
         end
         S_JOIN: begin
            sum_in      = sum;
            right_in    = v_ff + rgt_ff[VALUE_BITS-1:0];
            wr_right_in = !dup;
            if (!dup && sum > best_ff) begin
               best_in = sum;
            end
            state_in = S_RIGHT;
         end
         S_RIGHT: begin
            if (advance) begin
               rsp_tvalid_in = 1'b1;
               rsp_best_in   = best_ff;
               rsp_last_in   = last_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         pend_ff       <= 1'b0;
         epoch_ff      <= EPOCH_FIRST;
         best_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         pend_ff       <= pend_in;
         epoch_ff      <= epoch_in;
         best_ff       <= best_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      v_ff        <= v_in;
      last_ff     <= last_in;
      lft_ff      <= lft_in;
      rgt_ff      <= rgt_in;
      sum_ff      <= sum_in;
      right_ff    <= right_in;
      wr_right_ff <= wr_right_in;
      rsp_best_ff <= rsp_best_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-LEN_FIELD_W){1'b0}}, len_field(rsp_best_ff)};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while the previous one is still in flight");

   a_rsp_from_right_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_RIGHT))
      else $error("response raised outside the final stage");

   a_epoch_never_free_tag: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != TAG_NONE)
      else $error("current epoch equals the cleared tag");

   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      best_ff <= len_type'(DEPTH))
      else $error("best length beyond the value range");
`endif

endmodule

@@ hdl/lcrt_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module lcrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
